/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the dedup table modules.
// The module that includes this file must have clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge, off while reset is asserted
`define ASSERT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never hold outside reset
`define ASSERT_NEVER(name, expr, msg) \
	`ASSERT_CLK(name, !(expr), msg)

`endif

/* hdl/tdt_pkg.sv */
// ----------------------------------------------------------------------------
// tdt_pkg
// Shared sizes, register map and controller/datapath bundles of the
// time-to-live duplicate filter.
// ----------------------------------------------------------------------------
package tdt_pkg;

	// table geometry and field widths
	localparam int unsigned MAX_ENTRIES = 256;
	localparam int unsigned KEY_BITS    = 64;
	localparam int unsigned TIME_BITS   = 48;
	localparam int unsigned TTL_BITS    = 32;
	localparam int unsigned IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned DIFF_W      = (TIME_BITS > TTL_BITS) ? TIME_BITS : TTL_BITS;

	// configuration port
	localparam int unsigned APB_ADDR_W  = 3;
	localparam int unsigned APB_DATA_W  = 32;
	localparam logic        REG_IDX_TTL = 1'b0;
	localparam logic [TTL_BITS-1:0] TTL_RESET = TTL_BITS'(60000);

	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [KEY_BITS-1:0]  key_t;
	typedef logic [TIME_BITS-1:0] stamp_t;
	typedef logic [TTL_BITS-1:0]  ttl_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;        // latch the incoming word
		logic evict;       // drop the oldest entry
		logic scan_start;  // begin the key scan at the oldest entry
		logic scan_step;   // issue the next key read / compare
		logic insert;      // append the key, dropping the oldest if full
	} tdt_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic empty;       // no live entries
		logic expired;     // oldest entry is past its time-to-live
		logic hit;         // key compare matched a live entry
		logic scan_done;   // all live entries have been read
	} tdt_sts_t;

	// ring pointer increment with wrap at the table depth
	function automatic idx_t idx_inc(input idx_t idx);
		idx_t nxt;
		nxt = (idx == IDX_W'(MAX_ENTRIES - 1)) ? '0 : idx + 1'b1;
		return nxt;
	endfunction

endpackage

/* hdl/tdt_if.sv */
// ----------------------------------------------------------------------------
// tdt_if
// Valid/ready channels of the dedup table: request words and result words.
// ----------------------------------------------------------------------------
interface tdt_item_if import tdt_pkg::*; ();
	logic   valid;
	logic   ready;
	key_t   key;
	stamp_t now_ms;

	modport source (output valid, key, now_ms, input ready);
	modport sink   (input valid, key, now_ms, output ready);
endinterface

interface tdt_result_if import tdt_pkg::*; ();
	logic valid;
	logic ready;
	logic first_seen;

	modport source (output valid, first_seen, input ready);
	modport sink   (input valid, first_seen, output ready);
endinterface

/* hdl/tdt_ctrl.sv */
// ----------------------------------------------------------------------------
// tdt_ctrl
// Sequencer of the dedup table: evict walk, key scan, insert, and the
// result register that parts the output side from the work.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tdt_ctrl import tdt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	output logic     res_valid,
	input  logic     res_ready,
	output logic     res_first_seen,
	output tdt_cmd_t cmd,
	input  tdt_sts_t sts
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EV_CHK = 3'd1;
	localparam logic [2:0] ST_EV_WT  = 3'd2;
	localparam logic [2:0] ST_SCAN   = 3'd3;
	localparam logic [2:0] ST_INSERT = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0] state_q, state_d;
	logic       pend_first_q, pend_first_d;
	logic       res_valid_q;
	logic       res_first_q;
	logic       res_load;

	assign item_ready     = (state_q == ST_IDLE);
	assign res_valid      = res_valid_q;
	assign res_first_seen = res_first_q;

	// next state and commands
	always_comb begin
		state_d      = state_q;
		pend_first_d = pend_first_q;
		cmd          = '0;
		res_load     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EV_CHK;
				end
			end
			ST_EV_CHK: begin
				if (sts.empty || !sts.expired) begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end else begin
					cmd.evict = 1'b1;
					state_d   = ST_EV_WT;
				end
			end
			// stamp read of the new oldest slot lands in the next cycle
			ST_EV_WT: begin
				state_d = ST_EV_CHK;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.hit) begin
					pend_first_d = 1'b0;
					state_d      = ST_DONE;
				end else if (sts.scan_done) begin
					state_d = ST_INSERT;
				end
			end
			ST_INSERT: begin
				cmd.insert   = 1'b1;
				pend_first_d = 1'b1;
				state_d      = ST_DONE;
			end
			ST_DONE: begin
				if (!res_valid_q || res_ready) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pend_first_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			pend_first_q <= pend_first_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_first_q <= pend_first_q;
		end
	end

	`ASSERT_CLK(a_accept_to_check, (item_valid && item_ready) |=> (state_q == ST_EV_CHK), "accepted word did not start the evict check")
	`ASSERT_NEVER(a_evict_and_scan, cmd.evict && cmd.scan_start, "evict and scan start issued together")
	`ASSERT_CLK(a_res_slot_free, res_load |-> (!res_valid_q || res_ready), "result register overwritten while full")
	`ASSERT_CLK(a_hit_is_dup, (state_q == ST_SCAN && sts.hit) |=> !pend_first_q, "hit not reported as duplicate")

endmodule

/* hdl/tdt_dpath.sv */
// ----------------------------------------------------------------------------
// tdt_dpath
// Datapath of the dedup table: key and stamp memories, ring pointers,
// expiry check and the key compare of the scan.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tdt_dpath import tdt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  tdt_cmd_t cmd,
	input  key_t     key,
	input  stamp_t   now_ms,
	input  ttl_t     ttl_ms,
	output tdt_sts_t sts
);

	// storage; live entries are the slots oldest .. oldest+count-1
	key_t   key_mem   [MAX_ENTRIES];
	stamp_t stamp_mem [MAX_ENTRIES];

	key_t   key_q;
	stamp_t now_q;
	idx_t   oldest_q;
	idx_t   tail_q;
	cnt_t   count_q;
	idx_t   scan_ptr_q;
	cnt_t   scan_left_q;
	logic   rd_vld_s1;
	key_t   key_rd_s1;
	stamp_t stamp_rd_s1;

	logic              full;
	stamp_t            age;
	logic [DIFF_W-1:0] age_ext;
	logic [CNT_W:0]    live_end;
	logic [CNT_W:0]    live_wrap;

	assign full = (count_q == CNT_W'(MAX_ENTRIES));

	// expiry of the oldest entry; a time before its stamp is not expired
	always_comb begin
		age     = now_q - stamp_rd_s1;
		age_ext = DIFF_W'(age);
	end

	assign sts.empty     = (count_q == '0);
	assign sts.expired   = (now_q >= stamp_rd_s1) && (age_ext > DIFF_W'(ttl_ms));
	assign sts.hit       = rd_vld_s1 && (key_rd_s1 == key_q);
	assign sts.scan_done = (scan_left_q == '0);

	// incoming word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= key;
			now_q <= now_ms;
		end
	end

	// ring pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			tail_q   <= '0;
			count_q  <= '0;
		end else if (cmd.evict) begin
			oldest_q <= idx_inc(oldest_q);
			count_q  <= count_q - 1'b1;
		end else if (cmd.insert) begin
			tail_q <= idx_inc(tail_q);
			if (full) begin
				oldest_q <= idx_inc(oldest_q);
			end else begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// scan sequencer: one key read issued per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_ptr_q  <= '0;
			scan_left_q <= '0;
			rd_vld_s1   <= 1'b0;
		end else if (cmd.scan_start) begin
			scan_ptr_q  <= oldest_q;
			scan_left_q <= count_q;
			rd_vld_s1   <= 1'b0;
		end else if (cmd.scan_step) begin
			if (scan_left_q != '0) begin
				scan_ptr_q  <= idx_inc(scan_ptr_q);
				scan_left_q <= scan_left_q - 1'b1;
				rd_vld_s1   <= 1'b1;
			end else begin
				rd_vld_s1 <= 1'b0;
			end
		end
	end

	// memories: one write port, one registered read port each
	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			key_mem[tail_q]   <= key_q;
			stamp_mem[tail_q] <= now_q;
		end
		key_rd_s1   <= key_mem[scan_ptr_q];
		stamp_rd_s1 <= stamp_mem[oldest_q];
	end

	// expected tail position, for checking only
	always_comb begin
		live_end  = (CNT_W+1)'(oldest_q) + (CNT_W+1)'(count_q);
		live_wrap = (live_end >= (CNT_W+1)'(MAX_ENTRIES)) ?
			live_end - (CNT_W+1)'(MAX_ENTRIES) : live_end;
	end

	`ASSERT_NEVER(a_count_range, count_q > CNT_W'(MAX_ENTRIES), "fill count beyond table depth")
	`ASSERT_NEVER(a_evict_empty, cmd.evict && (count_q == '0), "evict on an empty table")
	`ASSERT_CLK(a_tail_track, tail_q == IDX_W'(live_wrap), "tail pointer lost track of oldest plus count")
	`ASSERT_CLK(a_full_insert, (cmd.insert && full) |=> full, "insert into a full table changed the count")

endmodule

/* hdl/ttl_dedup_table_core.sv */
// The block takes a new word only once the result of the last one is in the result
//   register; the key scan reads one slot of the key memory per cycle and each
//   eviction costs a stamp read and a check.
// Reset: table empty and ttl_ms = 60000 at once; no clearing pass.
// ----------------------------------------------------------------------------
// ttl_dedup_table_core
// Duplicate filter with time-to-live and oldest-first eviction; top level
// with the register port, sequencer and datapath.
// ----------------------------------------------------------------------------
module ttl_dedup_table_core import tdt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	tdt_item_if.sink              item,
	tdt_result_if.source          result
);

	ttl_t     ttl_q;
	tdt_cmd_t cmd;
	tdt_sts_t sts;
	logic     reg_sel_ttl;

	// register port
	assign pready      = 1'b1;
	assign reg_sel_ttl = (paddr[2] == REG_IDX_TTL);
	assign prdata      = reg_sel_ttl ? APB_DATA_W'(ttl_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q <= TTL_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel_ttl) begin
			ttl_q <= TTL_BITS'(pwdata);
		end
	end

	tdt_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item.valid),
		.item_ready     (item.ready),
		.res_valid      (result.valid),
		.res_ready      (result.ready),
		.res_first_seen (result.first_seen),
		.cmd            (cmd),
		.sts            (sts)
	);

	tdt_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.key    (item.key),
		.now_ms (item.now_ms),
		.ttl_ms (ttl_q),
		.sts    (sts)
	);

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for ttl_dedup_table_core. A directed table walks the
// time-to-live edges, time going backwards and stale entries stuck behind a
// live one. Randomized phases follow, one per ttl_ms setting (zero, all ones
// and values in between), mixing repeated and fresh keys so the table fills
// and wraps. Each accepted request word is run through a local model of the
// filter, and every result word is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import tdt_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 4;
	localparam int IDLE_MAX       = 12;
	// worst request: full eviction walk plus a full scan
	localparam int LATENCY_TAIL   = 5 + 3 * MAX_ENTRIES;
	localparam int WATCHDOG_LIMIT = 10 * LATENCY_TAIL;
	localparam int REPORT_MAX     = 10;
	localparam int POOL_MAX       = 512;
	localparam int N_DIRECTED     = 14;
	localparam int N_PHASES       = 6;
	localparam logic [APB_ADDR_W-1:0] TTL_ADDR = APB_ADDR_W'(4 * int'(REG_IDX_TTL));

	typedef struct packed {
		key_t   key;
		stamp_t now;
		logic   known;       // expected value typed in below
		logic   first_seen;
	} dir_row_t;

	typedef struct {
		ttl_t ttl;
		int   items;
		int   pool_n;
		int   step_max;
		int   fresh_pct;
		int   jump_pct;
	} phase_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	tdt_item_if   item_ch ();
	tdt_result_if result_ch ();

	ttl_dedup_table_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (item_ch),
		.result  (result_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// filter shadow state
	key_t   ring_key   [MAX_ENTRIES];
	stamp_t ring_stamp [MAX_ENTRIES];
	logic   ring_live  [MAX_ENTRIES];
	idx_t   oldest_slot;
	cnt_t   fill_cnt;
	ttl_t   ttl_shadow;

	logic   first_seen_q [$];
	int     mismatch_count = 0;
	key_t   key_pool [POOL_MAX];

	// directed words, ttl_ms at its reset value
	dir_row_t directed_rows [N_DIRECTED] = '{
		'{64'h0, 48'h0, 1'b1, 1'b1},
		'{64'h0, 48'h0, 1'b1, 1'b0},
		'{64'hFFFF_FFFF_FFFF_FFFF, 48'h0, 1'b1, 1'b1},
		// age equal to ttl is still live
		'{64'hFFFF_FFFF_FFFF_FFFF, 48'd60000, 1'b1, 1'b0},
		// both entries now one past ttl
		'{64'h0, 48'd60001, 1'b1, 1'b1},
		'{64'hFFFF_FFFF_FFFF_FFFF, 48'd60001, 1'b1, 1'b1},
		// max time flushes the table
		'{64'h5555_5555_5555_5555, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1},
		// time before the stamp: not expired
		'{64'h5555_5555_5555_5555, 48'd100, 1'b1, 1'b0},
		'{64'hAAAA_AAAA_AAAA_AAAA, 48'd100, 1'b1, 1'b1},
		// stale entry behind a live oldest one still matches
		'{64'hAAAA_AAAA_AAAA_AAAA, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0},
		'{64'h0123_4567_89AB_CDEF, 48'h8000_0000_0000, 1'b0, 1'b0},
		'{64'h0, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0},
		'{64'hFEDC_BA98_7654_3210, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0},
		'{64'h5555_5555_5555_5555, 48'h0000_0001_0000, 1'b0, 1'b0}
	};

	function automatic void flag_error(input string msg);
		if (mismatch_count < REPORT_MAX)
			$display("ERROR @%0t: %s", $realtime, msg);
		mismatch_count++;
	endfunction

	function automatic void retire_oldest();
		if (fill_cnt != 0) begin
			ring_live[oldest_slot] = 1'b0;
			oldest_slot = idx_t'((int'(oldest_slot) + 1) % MAX_ENTRIES);
			fill_cnt--;
		end
	endfunction

	// one request through the shadow table; returns first_seen
	function automatic logic predict_first_seen(input key_t k, input stamp_t now);
		idx_t slot;
		logic expired;
		// oldest-end eviction, stops at the first unexpired entry
		while (fill_cnt != 0) begin
			slot    = oldest_slot;
			expired = (now >= ring_stamp[slot]) &&
			          ((now - ring_stamp[slot]) > stamp_t'(ttl_shadow));
			if (!expired)
				break;
			retire_oldest();
		end
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (ring_live[i] && ring_key[i] == k)
				return 1'b0;
		end
		// full table: overwrite the oldest
		if (fill_cnt >= MAX_ENTRIES)
			retire_oldest();
		slot = idx_t'((int'(oldest_slot) + int'(fill_cnt)) % MAX_ENTRIES);
		ring_key[slot]   = k;
		ring_stamp[slot] = now;
		ring_live[slot]  = 1'b1;
		fill_cnt++;
		return 1'b1;
	endfunction

	// idle draw with occasional back-to-back stretches
	function automatic int draw_idle(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, IDLE_MAX);
	endfunction

	// present one request word, hold until taken, record the prediction
	task automatic send_word(input key_t k, input stamp_t t, input logic use_typed,
	                         input logic typed);
		logic pred;
		item_ch.valid  <= 1'b1;
		item_ch.key    <= k;
		item_ch.now_ms <= t;
		do @(posedge clk); while (!item_ch.ready);
		pred = predict_first_seen(k, t);
		first_seen_q.insert(first_seen_q.size(), use_typed ? typed : pred);
	endtask

	// write ttl_ms, then read it back
	task automatic write_ttl(input ttl_t value);
		logic [APB_DATA_W-1:0] rd;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= TTL_ADDR;
		pwdata  <= APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		ttl_shadow = value;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== APB_DATA_W'(value))
			flag_error($sformatf("ttl_ms readback: expected %h, got %h", value, rd));
	endtask

	task automatic wait_drained();
		while (first_seen_q.size() != 0)
			@(posedge clk);
	endtask

	// result side: random stalls, compare against oldest prediction
	initial begin
		int   calm;
		int   stall;
		logic want;
		calm = 0;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_idle(calm);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			if (first_seen_q.size() == 0) begin
				flag_error($sformatf("result word with nothing pending (first_seen=%b)",
				                     result_ch.first_seen));
			end else begin
				want = first_seen_q[0];
				first_seen_q.delete(0);
				if (result_ch.first_seen !== want)
					flag_error($sformatf("first_seen: expected %b, got %b",
					                     want, result_ch.first_seen));
			end
		end
	end

	// stall watchdog: cycles with no handshake of any kind
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) || psel)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("ttl_dedup_table_core test failed");
		$finish;
	end

	// stimulus
	initial begin
		phase_t plan [N_PHASES];
		int     calm;
		int     gap;
		key_t   k;
		stamp_t now_cur;

		arst_n         <= 1'b0;
		psel           <= 1'b0;
		penable        <= 1'b0;
		pwrite         <= 1'b0;
		paddr          <= '0;
		pwdata         <= '0;
		item_ch.valid  <= 1'b0;
		item_ch.key    <= '0;
		item_ch.now_ms <= '0;

		for (int i = 0; i < MAX_ENTRIES; i++)
			ring_live[i] = 1'b0;
		oldest_slot = '0;
		fill_cnt    = '0;
		ttl_shadow  = TTL_RESET;
		calm        = 0;

		plan[0] = '{32'h0,           200, 16,  2,    15, 3};
		plan[1] = '{32'hFFFF_FFFF,   450, 320, 3,    55, 0};
		plan[2] = '{32'd50,          300, 24,  15,   15, 4};
		plan[3] = '{32'd1000,        300, 64,  60,   20, 4};
		plan[4] = '{ttl_t'($urandom_range(1, 3000)), 250, 40, 200, 20, 5};
		plan[5] = '{TTL_RESET,       200, 32,  4000, 20, 5};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int r = 0; r < N_DIRECTED; r++) begin
			gap = draw_idle(calm);
			if (gap > 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			send_word(directed_rows[r].key, directed_rows[r].now,
			          directed_rows[r].known, directed_rows[r].first_seen);
		end
		item_ch.valid <= 1'b0;

		// random phases, one ttl setting each, written with the table idle
		for (int p = 0; p < N_PHASES; p++) begin
			wait_drained();
			write_ttl(plan[p].ttl);
			for (int i = 0; i < plan[p].pool_n; i++)
				key_pool[i] = {$urandom, $urandom};
			now_cur = stamp_t'({$urandom, $urandom});
			for (int n = 0; n < plan[p].items; n++) begin
				if ($urandom_range(0, 99) < plan[p].fresh_pct)
					k = {$urandom, $urandom};
				else
					k = key_pool[$urandom_range(0, plan[p].pool_n - 1)];
				// mostly forward time, occasional jumps either way
				if ($urandom_range(0, 99) < plan[p].jump_pct)
					now_cur = stamp_t'({$urandom, $urandom});
				else
					now_cur = now_cur + stamp_t'($urandom_range(0, plan[p].step_max));
				gap = draw_idle(calm);
				if (gap > 0) begin
					item_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				send_word(k, now_cur, 1'b0, 1'b0);
			end
			item_ch.valid <= 1'b0;
		end

		wait_drained();
		repeat (LATENCY_TAIL) @(posedge clk);
		if (mismatch_count == 0 && first_seen_q.size() == 0)
			$display("ttl_dedup_table_core test passed");
		else
			$display("ttl_dedup_table_core test failed");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hdl
hdl/tdt_pkg.sv
hdl/tdt_if.sv
hdl/tdt_ctrl.sv
hdl/tdt_dpath.sv
hdl/ttl_dedup_table_core.sv
dv/tb_top.sv
